// ===== rtl/rau_pkg.sv =====
// Shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
package rau_pkg;

    localparam int W  = 32;          // operand width
    localparam int PW = 2 * W + 1;   // product and sum width (magnitude)

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_DIVZ = 2'd2,
        ST_OVF  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_CHECK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_PACK,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic mul3;
        logic sum;
        logic gcd_start;
        logic gcd_step;
        logic divn_start;
        logic divd_start;
        logic div_step;
        logic pack;
        logic set_zden;
        logic set_divz;
        logic set_zero;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zden;
        logic dzero;
        logic nzero;
        logic gcd_done;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/rau_datapath.sv =====
// Datapath of the rational arithmetic unit: products, sums, GCD and divisions.
`timescale 1ns / 1ps
module rau_datapath
    import rau_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [1:0]  in_mode,
    input  logic [W-1:0] in_an,
    input  logic [W-1:0] in_ad,
    input  logic [W-1:0] in_bn,
    input  logic [W-1:0] in_bd,
    output logic [W-1:0] res_num,
    output logic [W-2:0] res_den,
    output logic [2:0]  cmp,
    output logic [1:0]  st
);

    logic [1:0]    mode_reg;
    logic          an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [W-1:0]  an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic [PW-1:0] ca_reg, cb_reg, dd_reg, nn_reg, dx_reg;
    logic          ca_s_reg, cb_s_reg, nn_s_reg, dx_s_reg;
    logic [PW-1:0] n_reg, d_reg;
    logic          rneg_reg;
    logic [PW-1:0] gx_reg, gy_reg;
    logic [PW-1:0] q_reg, r_reg, dv_reg;
    logic [6:0]    cnt_reg;
    logic [PW-1:0] nm_reg;
    logic [W-1:0]  rnum_reg;
    logic [W-2:0]  rden_reg;
    logic [2:0]    cmp_reg;
    logic [1:0]    st_reg;
    logic          gmode_reg; // 1 while the shared divider computes a GCD remainder

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    // Signed magnitude add: returns {sign, magnitude}.
    function automatic logic [PW:0] smadd(input logic as, input logic [PW-1:0] am,
                                          input logic bs, input logic [PW-1:0] bm);
        logic [PW-1:0] m;
        logic          s;
        if (as == bs)
        begin
            m = am + bm;
            s = as;
        end
        else if (am >= bm)
        begin
            m = am - bm;
            s = as;
        end
        else
        begin
            m = bm - am;
            s = bs;
        end
        return {s && (m != '0), m};
    endfunction

    logic [PW:0]   sum_ab, diff_ab;
    logic [PW:0]   rem_sh;
    logic [PW-1:0] rem_nx;
    logic          rem_ge;
    logic [PW-1:0] half;

    assign sum_ab  = smadd(ca_s_reg, ca_reg, cb_s_reg, cb_reg);
    assign diff_ab = smadd(ca_s_reg, ca_reg, !cb_s_reg && (cb_reg != '0), cb_reg);

    // Restoring division step, one quotient bit a cycle.
    assign rem_sh = {r_reg, q_reg[PW-1]};
    assign rem_ge = rem_sh >= {1'b0, dv_reg};
    assign rem_nx = rem_ge ? PW'(rem_sh - {1'b0, dv_reg}) : rem_sh[PW-1:0];
    assign half   = PW'(1) << (W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            gmode_reg <= 1'b0;
        end
        else
        begin
            if (cmd.gcd_start || (cmd.gcd_step && cnt_reg == '0 && gy_reg != '0))
            begin
                cnt_reg   <= 7'(PW);
                gmode_reg <= 1'b1;
            end
            else if (cmd.divn_start || cmd.divd_start)
            begin
                cnt_reg   <= 7'(PW);
                gmode_reg <= 1'b0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            an_s_reg <= in_an[W-1]; an_m_reg <= mag(in_an);
            ad_s_reg <= in_ad[W-1]; ad_m_reg <= mag(in_ad);
            bn_s_reg <= in_bn[W-1]; bn_m_reg <= mag(in_bn);
            bd_s_reg <= in_bd[W-1]; bd_m_reg <= mag(in_bd);
        end
        if (cmd.mul1)
        begin
            ca_reg   <= PW'(an_m_reg * bd_m_reg);
            ca_s_reg <= an_s_reg ^ bd_s_reg;
            cb_reg   <= PW'(bn_m_reg * ad_m_reg);
            cb_s_reg <= bn_s_reg ^ ad_s_reg;
        end
        if (cmd.mul2)
        begin
            dd_reg   <= PW'(ad_m_reg * bd_m_reg);
            nn_reg   <= PW'(an_m_reg * bn_m_reg);
            nn_s_reg <= an_s_reg ^ bn_s_reg;
        end
        if (cmd.mul3)
        begin
            dx_reg   <= PW'(ad_m_reg * bn_m_reg);
            dx_s_reg <= ad_s_reg ^ bn_s_reg;
            ca_s_reg <= ca_s_reg && (ca_reg != '0);
            cb_s_reg <= cb_s_reg && (cb_reg != '0);
        end
        if (cmd.sum)
        begin
            // Compare: sign of the difference against the sign of the denominator product.
            if (diff_ab[PW-1:0] == '0)
                cmp_reg <= 3'b010;
            else if (diff_ab[PW] != (ad_s_reg ^ bd_s_reg))
                cmp_reg <= 3'b100;
            else
                cmp_reg <= 3'b001;
            unique case (mode_t'(mode_reg))
                MODE_ADD:
                begin
                    n_reg <= sum_ab[PW-1:0];
                    d_reg <= dd_reg;
                    rneg_reg <= sum_ab[PW] ^ (ad_s_reg ^ bd_s_reg);
                end
                MODE_SUB:
                begin
                    n_reg <= diff_ab[PW-1:0];
                    d_reg <= dd_reg;
                    rneg_reg <= diff_ab[PW] ^ (ad_s_reg ^ bd_s_reg);
                end
                MODE_MUL:
                begin
                    n_reg <= nn_reg;
                    d_reg <= dd_reg;
                    rneg_reg <= (nn_s_reg && nn_reg != '0) ^ (ad_s_reg ^ bd_s_reg);
                end
                default:
                begin
                    n_reg <= ca_reg;
                    d_reg <= dx_reg;
                    rneg_reg <= ca_s_reg ^ (dx_s_reg && dx_reg != '0);
                end
            endcase
        end
        if (cmd.gcd_start)
        begin
            gx_reg <= n_reg;
            gy_reg <= d_reg;
            q_reg  <= n_reg;
            r_reg  <= '0;
            dv_reg <= d_reg;
        end
        else if (cmd.gcd_step && cnt_reg == '0 && gy_reg != '0)
        begin
            // Remainder r_reg is ready: x, y <- y, x mod y; start the next remainder.
            gx_reg <= gy_reg;
            gy_reg <= r_reg;
            q_reg  <= gy_reg;
            r_reg  <= '0;
            dv_reg <= r_reg;
        end
        else if (cmd.divn_start || cmd.divd_start)
        begin
            if (cmd.divd_start)
                nm_reg <= q_reg;
            q_reg  <= cmd.divn_start ? n_reg : d_reg;
            r_reg  <= '0;
            dv_reg <= gx_reg;
        end
        else if (cnt_reg != '0)
        begin
            r_reg <= rem_nx;
            q_reg <= {q_reg[PW-2:0], rem_ge};
        end
        if (cmd.pack)
        begin
            if (q_reg > half - 1'b1 || (rneg_reg ? nm_reg > half : nm_reg > half - 1'b1))
            begin
                st_reg <= ST_OVF; rnum_reg <= '0; rden_reg <= (W-1)'(1);
            end
            else
            begin
                st_reg   <= ST_OK;
                rnum_reg <= rneg_reg ? W'(~nm_reg + 1'b1) : nm_reg[W-1:0];
                rden_reg <= q_reg[W-2:0];
            end
        end
        if (cmd.set_zden)
        begin
            st_reg <= ST_ZDEN; rnum_reg <= '0; rden_reg <= (W-1)'(1); cmp_reg <= '0;
        end
        if (cmd.set_divz)
        begin
            st_reg <= ST_DIVZ; rnum_reg <= '0; rden_reg <= (W-1)'(1);
        end
        if (cmd.set_zero)
        begin
            st_reg <= ST_OK; rnum_reg <= '0; rden_reg <= (W-1)'(1);
        end
    end

    // In GCD mode the divider leaves x/y's quotient aside; only the remainder is used.
    assign sts.zden     = (ad_m_reg == '0) || (bd_m_reg == '0);
    assign sts.dzero    = (d_reg == '0);
    assign sts.nzero    = (n_reg == '0);
    assign sts.gcd_done = (cnt_reg == '0) && gmode_reg && (gy_reg == '0);
    assign sts.div_done = (cnt_reg == '0) && !gmode_reg;

    assign res_num = rnum_reg;
    assign res_den = rden_reg;
    assign cmp     = cmp_reg;
    assign st      = st_reg;

endmodule

// ===== rtl/rau_ctrl.sv =====
// Controller state machine of the rational arithmetic unit.
`timescale 1ns / 1ps
module rau_ctrl
    import rau_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_fire,
    input  logic out_fire,
    input  sts_t sts,
    output cmd_t cmd,
    output logic in_rdy,
    output logic out_vld
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // The GCD and the two divisions share the datapath's divider; the
    // first cycle of each division state launches it, then waits on done.
    logic first_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_reg <= 1'b0;
        else
            first_reg <= (state_next != state_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_fire) state_next = S_MUL1;
            S_MUL1:  state_next = sts.zden ? S_OUT : S_MUL2;
            S_MUL2:  state_next = S_MUL3;
            S_MUL3:  state_next = S_SUM;
            S_SUM:   state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.dzero || sts.nzero)
                    state_next = S_OUT;
                else
                    state_next = S_GCD;
            end
            S_GCD:   if (sts.gcd_done) state_next = S_DIVN;
            // Done still shows the previous division in the launch cycle.
            S_DIVN:  if (!first_reg && sts.div_done) state_next = S_DIVD;
            S_DIVD:  if (!first_reg && sts.div_done) state_next = S_PACK;
            S_PACK:  state_next = S_OUT;
            S_OUT:   if (out_fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        in_rdy  = 1'b0;
        out_vld = 1'b0;
        unique case (state_reg)
            S_IDLE:  begin in_rdy = 1'b1; cmd.load = in_fire; end
            S_MUL1:  begin cmd.mul1 = 1'b1; cmd.set_zden = sts.zden; end
            S_MUL2:  cmd.mul2 = 1'b1;
            S_MUL3:  cmd.mul3 = 1'b1;
            S_SUM:   cmd.sum = 1'b1;
            S_CHECK:
            begin
                cmd.set_divz  = sts.dzero;
                cmd.set_zero  = !sts.dzero && sts.nzero;
                cmd.gcd_start = !sts.dzero && !sts.nzero;
            end
            S_GCD:   cmd.gcd_step = 1'b1;
            S_DIVN:  cmd.divn_start = first_reg;
            S_DIVD:  cmd.divd_start = first_reg;
            S_PACK:  cmd.pack = 1'b1;
            S_OUT:   out_vld = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== rtl/rational_arithmetic_unit_core.sv =====
// Top level of the rational arithmetic unit.
// Usage: the slave channel (s_axis_*) takes one item holding an operation
// code and two signed fractions; the master channel (m_axis_*) returns one
// item with the reduced result, the compare flags and a status code.
// One item is in work at a time: s_axis_tready is high only while idle.
// Products and checks come first; then the shared restoring divider, one
// quotient bit a cycle over 65 bits, computes each Euclid remainder and
// then the two final divisions by the GCD, and the result is packed.
// Zero denominators, a zero divisor or a zero result skip the GCD and the
// divisions. The next item can be taken in the cycle after the result is
// accepted.
// The result is held with m_axis_tvalid high until taken; while the
// receiver stalls, no new item is accepted.
// Reset (rst_n low, asynchronous) returns the block to idle and drops any
// item in work.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core
    import rau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_num, a_den, b_num, b_den from bit 0 up
    input  logic [127:0] s_axis_tdata,
    // mode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_num, res_den, less, equal, greater, status from bit 0 up, zero filled
    output logic [71:0]  m_axis_tdata
);

    cmd_t         cmd;
    sts_t         sts;
    logic [W-1:0] rnum;
    logic [W-2:0] rden;
    logic [2:0]   cmp;
    logic [1:0]   st;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .out_fire (m_axis_tvalid && m_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .in_rdy   (s_axis_tready),
        .out_vld  (m_axis_tvalid)
    );

    rau_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .in_mode (s_axis_tuser),
        .in_an   (s_axis_tdata[31:0]),
        .in_ad   (s_axis_tdata[63:32]),
        .in_bn   (s_axis_tdata[95:64]),
        .in_bd   (s_axis_tdata[127:96]),
        .res_num (rnum),
        .res_den (rden),
        .cmp     (cmp),
        .st      (st)
    );

    assign m_axis_tdata = {4'd0, st, cmp[0], cmp[1], cmp[2], rden, rnum};

endmodule

// ===== tb/sv/rational_arithmetic_unit_core_tb.sv =====
// Self-checking testbench of the rational arithmetic unit core.
`timescale 1ns / 1ps
module rational_arithmetic_unit_core_tb;
    import rau_pkg::*;

    typedef struct {
        mode_t       mode;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [31:0] b_den;
    } frac_op_t;

    typedef struct {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        less;
        logic        equal;
        logic        greater;
        status_t     status;
    } frac_res_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;

    frac_op_t  pending_ops[$];
    frac_res_t expected_res[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        stim_done = 0;
    bit        in_taken = 0;

    rational_arithmetic_unit_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sign and magnitude of a 32-bit operand.
    function automatic void split(input logic [31:0] x, output bit neg,
                                  output logic [63:0] mag);
        neg = x[31];
        mag = neg ? {32'd0, -x} : {32'd0, x};
    endfunction

    // Signed add on sign and magnitude pairs; zero is never negative.
    function automatic void sm_add(input bit an, input logic [63:0] am, input bit bn,
                                   input logic [63:0] bm, output bit rn,
                                   output logic [63:0] rm);
        if (an == bn)
        begin
            rm = am + bm;
            rn = an;
        end
        else if (am >= bm)
        begin
            rm = am - bm;
            rn = an;
        end
        else
        begin
            rm = bm - am;
            rn = bn;
        end
        if (rm == 0)
            rn = 1'b0;
    endfunction

    function automatic frac_res_t predict_fraction(input frac_op_t op);
        frac_res_t   r;
        bit          anN, adN, bnN, bdN, caN, cbN, dfN, nN, dN, rneg;
        logic [63:0] anM, adM, bnM, bdM, caM, cbM, dfM, nM, dM, x, y, t, nm, dm;
        r = '{32'd0, 31'd1, 1'b0, 1'b0, 1'b0, ST_OK};
        split(op.a_num, anN, anM);
        split(op.a_den, adN, adM);
        split(op.b_num, bnN, bnM);
        split(op.b_den, bdN, bdM);
        if (adM == 0 || bdM == 0)
        begin
            r.status = ST_ZDEN;
            return r;
        end
        caM = anM * bdM;
        caN = (anN != bdN) && caM != 0;
        cbM = bnM * adM;
        cbN = (bnN != adN) && cbM != 0;
        sm_add(caN, caM, !cbN && cbM != 0, cbM, dfN, dfM);
        if (dfM == 0)
            r.equal = 1'b1;
        else if (dfN != (adN != bdN))
            r.less = 1'b1;
        else
            r.greater = 1'b1;
        dM = adM * bdM;
        dN = adN != bdN;
        case (op.mode)
            MODE_ADD: sm_add(caN, caM, cbN, cbM, nN, nM);
            MODE_SUB:
            begin
                nN = dfN;
                nM = dfM;
            end
            MODE_MUL:
            begin
                nM = anM * bnM;
                nN = (anN != bnN) && nM != 0;
            end
            default:
            begin
                nN = caN;
                nM = caM;
                dM = adM * bnM;
                dN = adN != bnN;
            end
        endcase
        if (dM == 0)
            r.status = ST_DIVZ;
        else if (nM != 0)
        begin
            x = nM;
            y = dM;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            nm = nM / x;
            dm = dM / x;
            rneg = nN != dN;
            if (dm > 64'h7FFF_FFFF || (rneg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF))
                r.status = ST_OVF;
            else
            begin
                r.res_num = rneg ? -nm[31:0] : nm[31:0];
                r.res_den = dm[30:0];
            end
        end
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 12) - 6;
            1: return $urandom_range(0, 2000) - 1000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            3: return ($urandom_range(1, 200) * $urandom_range(1, 200))
                      * ($urandom_range(0, 1) ? -1 : 1);
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] rand_den();
        logic [31:0] d;
        d = rand_operand();
        if (d == 0 && $urandom_range(0, 3) != 0)
            d = 32'd1;
        return d;
    endfunction

    task automatic queue_op(input mode_t m, input logic [31:0] an, input logic [31:0] ad,
                            input logic [31:0] bn, input logic [31:0] bd);
        frac_op_t op;
        op = '{m, an, ad, bn, bd};
        pending_ops.push_back(op);
    endtask

    // Input acceptance is seen at the rising edge; the oldest pending item is retired.
    always @(posedge clk)
    begin
        in_taken <= rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_res.push_back(predict_fraction(pending_ops.pop_front()));
    end

    // Driver: presents queued items, changing inputs on the falling edge.
    always @(negedge clk)
    begin
        frac_op_t op;
        if (rst_n)
        begin
            if ((!s_axis_tvalid || in_taken) && pending_ops.size() > 0
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                op = pending_ops[0];
                s_axis_tdata  <= {op.b_den, op.b_num, op.a_den, op.a_num};
                s_axis_tuser  <= op.mode;
                s_axis_tvalid <= 1'b1;
            end
            else if (!s_axis_tvalid || in_taken)
                s_axis_tvalid <= 1'b0;
            m_axis_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    // Monitor: checks each accepted result item against the oldest prediction.
    always @(posedge clk)
    begin
        frac_res_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_res.size() == 0)
            begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expected_res.pop_front();
                if (m_axis_tdata[31:0] !== e.res_num)
                begin
                    $error("res_num expected %0d actual %0d", $signed(e.res_num),
                           $signed(m_axis_tdata[31:0]));
                    errors++;
                end
                if (m_axis_tdata[62:32] !== e.res_den)
                begin
                    $error("res_den expected %0d actual %0d", e.res_den, m_axis_tdata[62:32]);
                    errors++;
                end
                if (m_axis_tdata[63] !== e.less)
                begin
                    $error("less expected %0d actual %0d", e.less, m_axis_tdata[63]);
                    errors++;
                end
                if (m_axis_tdata[64] !== e.equal)
                begin
                    $error("equal expected %0d actual %0d", e.equal, m_axis_tdata[64]);
                    errors++;
                end
                if (m_axis_tdata[65] !== e.greater)
                begin
                    $error("greater expected %0d actual %0d", e.greater, m_axis_tdata[65]);
                    errors++;
                end
                if (m_axis_tdata[67:66] !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, m_axis_tdata[67:66]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int phase;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items: extremes, every operation and each special case.
        queue_op(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        queue_op(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        queue_op(MODE_MUL, -32'd2, 32'd4, 32'd3, -32'd9);
        queue_op(MODE_DIV, 32'd3, 32'd4, -32'd5, 32'd6);
        queue_op(MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        queue_op(MODE_DIV, 32'd1, 32'd1, 32'd5, 32'd0);
        queue_op(MODE_DIV, 32'd7, 32'd3, 32'd0, 32'd5);
        queue_op(MODE_MUL, 32'd0, -32'd3, 32'd9, 32'd2);
        queue_op(MODE_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
        queue_op(MODE_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        queue_op(MODE_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
        queue_op(MODE_DIV, 32'h8000_0000, 32'd1, 32'd1, 32'hFFFF_FFFF);
        queue_op(MODE_ADD, 32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
        queue_op(MODE_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(MODE_SUB, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
        queue_op(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_op(MODE_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        queue_op(MODE_ADD, 32'd0, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF);

        for (phase = 0; phase < 5; phase++)
        begin
            wait (pending_ops.size() == 0 && expected_res.size() == 0 && !s_axis_tvalid);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                3: begin send_idle_pct = 35; recv_stall_pct = 35; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (180)
                queue_op(mode_t'($urandom_range(0, 3)), rand_operand(), rand_den(),
                         rand_operand(), rand_den());
        end

        wait (pending_ops.size() == 0 && !s_axis_tvalid);
        wait (expected_res.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_res.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== rational_arithmetic_unit_core.f =====
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit_core.sv
tb/sv/rational_arithmetic_unit_core_tb.sv
